// ----- rtl/qesm_pkg.sv -----
// qesm_pkg: shared types, constants and helper functions for the quadrature
// encoder speed monitor. No dependencies; imported by every qesm module.
`default_nettype none

package qesm_pkg;

   // parameter defaults
   localparam int TIME_BITS_DEF   = 32;
   localparam int WEIGHT_FRAC_DEF = 16;

   // fixed field widths
   localparam int WEIGHT_BITS    = 24;
   localparam int SCALE_BITS     = 32;
   localparam int COUNT_BITS     = 16;
   localparam int SUM_BITS       = 64;
   localparam int NUM_BITS       = SCALE_BITS + COUNT_BITS;
   localparam int POS_BITS       = 32;
   localparam int SPEED_BITS     = 31;
   localparam int MIN_EDGE_BITS  = 8;
   localparam int FAULT_LIM_BITS = 8;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_EDGE_A = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_EDGE_B = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RISE_WEIGHT    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FALL_WEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_SCALE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_EDGES      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_TICKS     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_TICKS   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MISMATCH_LIMIT = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAULT_LIMIT    = 3'd7;

   // register reset values
   localparam logic [WEIGHT_BITS-1:0]    RISE_WEIGHT_RST    = 24'd65536;
   localparam logic [WEIGHT_BITS-1:0]    FALL_WEIGHT_RST    = 24'd65536;
   localparam logic [SCALE_BITS-1:0]     SPEED_SCALE_RST    = 32'd90000000;
   localparam logic [MIN_EDGE_BITS-1:0]  MIN_EDGES_RST      = 8'd3;
   localparam logic [COUNT_BITS-1:0]     IDLE_TICKS_RST     = 16'd10;
   localparam logic [COUNT_BITS-1:0]     WINDOW_TICKS_RST   = 16'd100;
   localparam logic [COUNT_BITS-1:0]     MISMATCH_LIMIT_RST = 16'd50;
   localparam logic [FAULT_LIM_BITS-1:0] FAULT_LIMIT_RST    = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WEIGH,
      ST_DIVIDE,
      ST_IDLECHK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } step_type;

   // handshake status of a multi-cycle arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // quadrature step from {old a, old b, new a, new b}
   function automatic step_type step_lookup(input logic [3:0] hist);
      step_type s;
      case (hist)
         4'h2, 4'h4, 4'hb, 4'hd: s = STEP_UP;
         4'h1, 4'h7, 4'h8, 4'he: s = STEP_DOWN;
         default:                s = STEP_NONE;
      endcase
      return s;
   endfunction

   function automatic logic [COUNT_BITS-1:0] inc_sat16(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/qesm_weigh.sv -----
// qesm_weigh: bit-serial shift-add multiplier that scales an edge period by a
// fixed-point duty weight, one weight bit per cycle. Depends on qesm_pkg.
`default_nettype none

module qesm_weigh #(
   parameter int TIME_BITS        = qesm_pkg::TIME_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = qesm_pkg::WEIGHT_FRAC_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [TIME_BITS-1:0]             period,
   input  wire logic [qesm_pkg::WEIGHT_BITS-1:0] weight,
   output qesm_pkg::unit_stat_type               stat,
   output logic [qesm_pkg::SUM_BITS-1:0]         product
);
   import qesm_pkg::*;

   localparam int PROD_BITS = TIME_BITS + WEIGHT_BITS;
   localparam int EXT_BITS  = PROD_BITS + SUM_BITS;
   localparam int CNT_BITS  = $clog2(WEIGHT_BITS + 1);

   logic [PROD_BITS-1:0]   mcand_ff, mcand_in;
   logic [PROD_BITS-1:0]   acc_ff, acc_in;
   logic [WEIGHT_BITS-1:0] mplier_ff, mplier_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [EXT_BITS-1:0]    acc_shifted;

   always_comb begin
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = PROD_BITS'(period);
         acc_in    = '0;
         mplier_in = weight;
         cnt_in    = CNT_BITS'(WEIGHT_BITS);
      end else if (cnt_ff != '0) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - CNT_BITS'(1);
         done_in   = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
   end

   // drop the fraction bits, saturate anything that does not fit 64 bits
   assign acc_shifted = EXT_BITS'(acc_ff) >> WEIGHT_FRAC_BITS;
   assign product     = (|acc_shifted[EXT_BITS-1:SUM_BITS]) ? '1 : acc_shifted[SUM_BITS-1:0];

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ----- rtl/qesm_div.sv -----
// qesm_div: restoring divider, one quotient bit per cycle, for the speed
// quotient (48-bit numerator over 64-bit period sum). Depends on qesm_pkg.
`default_nettype none

module qesm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [qesm_pkg::NUM_BITS-1:0] numerator,
   input  wire logic [qesm_pkg::SUM_BITS-1:0] divisor,
   output qesm_pkg::unit_stat_type            stat,
   output logic [qesm_pkg::NUM_BITS-1:0]      quotient
);
   import qesm_pkg::*;

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [SUM_BITS-1:0] rem_ff, rem_in;
   logic [SUM_BITS-1:0] div_ff, div_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [SUM_BITS:0]   rem_shift;
   logic [SUM_BITS:0]   rem_diff;
   logic                fits;

   assign rem_shift = {rem_ff, num_ff[NUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign fits      = (rem_shift >= {1'b0, div_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = numerator;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_BITS'(NUM_BITS);
      end else if (cnt_ff != '0) begin
         // partial remainder stays below the divisor, so 64 bits hold it
         rem_in  = fits ? rem_diff[SUM_BITS-1:0] : rem_shift[SUM_BITS-1:0];
         num_in  = {num_ff[NUM_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = num_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ----- rtl/quadrature_encoder_speed_monitor_core.sv -----
// quadrature_encoder_speed_monitor_core: top level of the encoder monitor.
// Depends on qesm_pkg, qesm_weigh and qesm_div.
//
// Every accepted item (A edge, B edge or service tick) returns exactly one
// result with position, direction, signed speed and fault. Items are handled
// one at a time. An edge that does not change channel A passes through the
// exec and done states to the result; an A change adds the serial period
// weighting (one weight bit per cycle over 24 bits). A tick passes through the
// idle check, and first through the restoring divider, which produces one of 48
// quotient bits per cycle, when a new speed is computed. The next item is
// taken as soon as the result sits in the output register, even if that
// result has not yet been transferred. The user must write registers through
// the csr port only while no item is in flight; the block does not enforce it.
`default_nettype none

module quadrature_encoder_speed_monitor_core #(
   parameter int TIME_BITS        = qesm_pkg::TIME_BITS_DEF,
   parameter int WEIGHT_FRAC_BITS = qesm_pkg::WEIGHT_FRAC_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [qesm_pkg::CMD_BITS-1:0]       req_command,
   input  wire logic                                req_level_a,
   input  wire logic                                req_level_b,
   input  wire logic [TIME_BITS-1:0]                req_timestamp,
   input  wire logic                                req_speed_commanded,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [qesm_pkg::POS_BITS-1:0]     rsp_position,
   output logic                                     rsp_direction,
   output logic signed [qesm_pkg::POS_BITS-1:0]     rsp_speed,
   output logic                                     rsp_fault,
   input  wire logic                                csr_wr_en,
   input  wire logic [qesm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [qesm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import qesm_pkg::*;

   // configuration registers
   logic [WEIGHT_BITS-1:0]    rise_w_ff, fall_w_ff;
   logic [SCALE_BITS-1:0]     scale_ff;
   logic [MIN_EDGE_BITS-1:0]  min_edges_ff;
   logic [COUNT_BITS-1:0]     idle_ticks_ff, window_ticks_ff, mismatch_ff;
   logic [FAULT_LIM_BITS-1:0] fault_limit_ff;

   // latched item
   logic [CMD_BITS-1:0]  cmd_ff, cmd_in;
   logic                 la_ff, la_in, lb_ff, lb_in, cmdd_ff, cmdd_in;
   logic [TIME_BITS-1:0] ts_ff, ts_in;

   // monitor state
   state_type            state_ff, state_in;
   logic [3:0]           hist_ff, hist_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic                 dir_ff, dir_in;
   logic [TIME_BITS-1:0] last_a_ff, last_a_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [COUNT_BITS-1:0] edge_cnt_ff, edge_cnt_in;
   logic [SPEED_BITS-1:0] speed_ff, speed_in;
   logic [COUNT_BITS-1:0] a_edges_ff, a_edges_in, b_edges_ff, b_edges_in;
   logic [COUNT_BITS-1:0] window_ff, window_in, bad_ff, bad_in, idle_ff, idle_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0] rsp_pos_ff, rsp_pos_in, rsp_speed_ff, rsp_speed_in;
   logic                rsp_dir_ff, rsp_dir_in, rsp_fault_ff, rsp_fault_in;

   // datapath helpers
   logic [3:0]           hist_new;
   step_type             step;
   logic                 a_change;
   logic [COUNT_BITS-1:0] edge_diff, bad_first;
   logic [SUM_BITS:0]    sum_add;
   logic [POS_BITS-1:0]  speed_ext;

   // arithmetic units
   logic                   mul_start, div_start;
   logic [TIME_BITS-1:0]   period;
   logic [WEIGHT_BITS-1:0] weight_sel;
   logic [SUM_BITS-1:0]    weighted;
   logic [NUM_BITS-1:0]    numer, quot;
   unit_stat_type          mul_stat, div_stat;

   assign hist_new   = {hist_ff[1:0], la_ff, lb_ff};
   assign step       = step_lookup(hist_new);
   assign a_change   = (hist_new[3] != hist_new[1]);
   assign period     = ts_ff - last_a_ff;
   assign weight_sel = hist_new[1] ? rise_w_ff : fall_w_ff;
   assign numer      = scale_ff * edge_cnt_ff;
   assign edge_diff  = (a_edges_ff > b_edges_ff) ? a_edges_ff - b_edges_ff
                                                 : b_edges_ff - a_edges_ff;
   assign bad_first  = (edge_diff > mismatch_ff) ? inc_sat16(bad_ff) : '0;
   assign sum_add    = {1'b0, sum_ff} + {1'b0, weighted};
   assign speed_ext  = {1'b0, speed_ff};

   assign mul_start = (state_ff == ST_EXEC) && (cmd_ff == CMD_EDGE_A || cmd_ff == CMD_EDGE_B)
                      && a_change;
   assign div_start = (state_ff == ST_EXEC) && (cmd_ff == CMD_TICK) && (sum_ff != '0)
                      && (edge_cnt_ff >= {8'd0, min_edges_ff});

   qesm_weigh #(
      .TIME_BITS        (TIME_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_weigh (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .period  (period),
      .weight  (weight_sel),
      .stat    (mul_stat),
      .product (weighted)
   );

   qesm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (numer),
      .divisor   (sum_ff),
      .stat      (div_stat),
      .quotient  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_w_ff       <= RISE_WEIGHT_RST;
         fall_w_ff       <= FALL_WEIGHT_RST;
         scale_ff        <= SPEED_SCALE_RST;
         min_edges_ff    <= MIN_EDGES_RST;
         idle_ticks_ff   <= IDLE_TICKS_RST;
         window_ticks_ff <= WINDOW_TICKS_RST;
         mismatch_ff     <= MISMATCH_LIMIT_RST;
         fault_limit_ff  <= FAULT_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RISE_WEIGHT:    rise_w_ff       <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_FALL_WEIGHT:    fall_w_ff       <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_SPEED_SCALE:    scale_ff        <= csr_wdata[SCALE_BITS-1:0];
            CSR_MIN_EDGES:      min_edges_ff    <= csr_wdata[MIN_EDGE_BITS-1:0];
            CSR_IDLE_TICKS:     idle_ticks_ff   <= csr_wdata[COUNT_BITS-1:0];
            CSR_WINDOW_TICKS:   window_ticks_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_MISMATCH_LIMIT: mismatch_ff     <= csr_wdata[COUNT_BITS-1:0];
            CSR_FAULT_LIMIT:    fault_limit_ff  <= csr_wdata[FAULT_LIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      ts_in        = ts_ff;
      cmdd_in      = cmdd_ff;
      hist_in      = hist_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      last_a_in    = last_a_ff;
      sum_in       = sum_ff;
      edge_cnt_in  = edge_cnt_ff;
      speed_in     = speed_ff;
      a_edges_in   = a_edges_ff;
      b_edges_in   = b_edges_ff;
      window_in    = window_ff;
      bad_in       = bad_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_fault_in = rsp_fault_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               la_in    = req_level_a;
               lb_in    = req_level_b;
               ts_in    = req_timestamp;
               cmdd_in  = req_speed_commanded;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_EDGE_A, CMD_EDGE_B: begin
                  if (cmd_ff == CMD_EDGE_A) a_edges_in = a_edges_ff + 16'd1;
                  else                      b_edges_in = b_edges_ff + 16'd1;
                  hist_in = hist_new;
                  case (step)
                     STEP_UP: begin
                        pos_in = pos_ff + 32'd1;
                        dir_in = 1'b1;
                     end
                     STEP_DOWN: begin
                        pos_in = pos_ff - 32'd1;
                        dir_in = 1'b0;
                     end
                     default: ;
                  endcase
                  if (a_change) begin
                     last_a_in = ts_ff;
                     state_in  = ST_WEIGH;
                  end else begin
                     state_in  = ST_DONE;
                  end
               end
               CMD_TICK: begin
                  if (window_ff > window_ticks_ff) begin
                     // window closes: judge a/b balance, then a dead channel a
                     bad_in     = (a_edges_ff == '0 && cmdd_ff) ? inc_sat16(bad_first)
                                                                : bad_first;
                     a_edges_in = '0;
                     b_edges_in = '0;
                     window_in  = 16'd1;
                  end else begin
                     window_in  = inc_sat16(window_ff);
                  end
                  state_in = div_start ? ST_DIVIDE : ST_IDLECHK;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WEIGH: begin
            if (mul_stat.done) begin
               sum_in      = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
               edge_cnt_in = inc_sat16(edge_cnt_ff);
               state_in    = ST_DONE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               speed_in    = (|quot[NUM_BITS-1:SPEED_BITS]) ? '1 : quot[SPEED_BITS-1:0];
               sum_in      = '0;
               edge_cnt_in = '0;
               idle_in     = '0;
               state_in    = ST_IDLECHK;
            end
         end
         ST_IDLECHK: begin
            if (idle_ff >= idle_ticks_ff) begin
               speed_in    = '0;
               sum_in      = '0;
               edge_cnt_in = '0;
               idle_in     = 16'd1;
            end else begin
               idle_in     = inc_sat16(idle_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_dir_in   = dir_ff;
               rsp_speed_in = dir_ff ? speed_ext : -speed_ext;
               rsp_fault_in = (bad_ff > {8'd0, fault_limit_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hist_ff      <= '0;
         pos_ff       <= '0;
         dir_ff       <= 1'b0;
         last_a_ff    <= '0;
         sum_ff       <= '0;
         edge_cnt_ff  <= '0;
         speed_ff     <= '0;
         a_edges_ff   <= '0;
         b_edges_ff   <= '0;
         window_ff    <= '0;
         bad_ff       <= '0;
         idle_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         pos_ff       <= pos_in;
         dir_ff       <= dir_in;
         last_a_ff    <= last_a_in;
         sum_ff       <= sum_in;
         edge_cnt_ff  <= edge_cnt_in;
         speed_ff     <= speed_in;
         a_edges_ff   <= a_edges_in;
         b_edges_ff   <= b_edges_in;
         window_ff    <= window_in;
         bad_ff       <= bad_in;
         idle_ff      <= idle_in;
      end
      cmd_ff       <= cmd_in;
      la_ff        <= la_in;
      lb_ff        <= lb_in;
      ts_ff        <= ts_in;
      cmdd_ff      <= cmdd_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_speed     = rsp_speed_ff;
   assign rsp_fault     = rsp_fault_ff;

   // a unit only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> state_ff == ST_WEIGH)
      else $error("weigh unit finished outside weigh state");

   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

   // a unit is never restarted while it is still working
   assert property (@(posedge clock) disable iff (reset)
      (mul_start || div_start) |-> !(mul_stat.busy || div_stat.busy))
      else $error("arithmetic unit restarted while busy");

   // a finished item always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("result lost at output register");

   // the idle timer counts every tick
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLECHK |=> idle_ff != '0)
      else $error("idle timer not advanced on tick");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for quadrature_encoder_speed_monitor_core.
// Depends on qesm_pkg and the core RTL; a directed table, then random encoder
// traffic in several register setups, checked by a predictor or by typed rows.

module tb_top;
   import qesm_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   // history codes that step the position up or down
   localparam logic [15:0] UP_STEPS    = 16'h2814;
   localparam logic [15:0] DOWN_STEPS  = 16'h4182;
   localparam int          GAP_PCT     = 7;
   localparam int          STALL_LIMIT = 2000;
   localparam int          NUM_PHASES  = 8;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic                level_a;
      logic                level_b;
      logic [31:0]         timestamp;
      logic                speed_commanded;
   } enc_event_type;

   typedef struct packed {
      logic [31:0] position;
      logic        direction;
      logic [31:0] speed;
      logic        fault;
   } enc_status_type;

   typedef struct {
      enc_event_type  ev;
      bit             typed;
      enc_status_type st;
   } stim_row_type;

   typedef struct {
      logic [23:0] rise;
      logic [23:0] fall;
      logic [31:0] scale;
      logic [7:0]  min_e;
      logic [15:0] idle;
      logic [15:0] win;
      logic [15:0] mis;
      logic [7:0]  flt;
      int          tick_pct;
      int          count;
      bit          quiet;
   } phase_cfg_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_BITS-1:0]        req_command = CMD_TICK;
   logic                       req_level_a = 1'b0;
   logic                       req_level_b = 1'b0;
   logic [TIME_BITS_DEF-1:0]   req_timestamp = '0;
   logic                       req_speed_commanded = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [POS_BITS-1:0] rsp_position;
   logic                       rsp_direction;
   logic signed [POS_BITS-1:0] rsp_speed;
   logic                       rsp_fault;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   // predictor registers
   logic [23:0] c_rise  = RISE_WEIGHT_RST;
   logic [23:0] c_fall  = FALL_WEIGHT_RST;
   logic [31:0] c_scale = SPEED_SCALE_RST;
   logic [7:0]  c_min   = MIN_EDGES_RST;
   logic [15:0] c_idle  = IDLE_TICKS_RST;
   logic [15:0] c_win   = WINDOW_TICKS_RST;
   logic [15:0] c_mis   = MISMATCH_LIMIT_RST;
   logic [7:0]  c_flt   = FAULT_LIMIT_RST;

   // predictor state
   logic [3:0]  p_hist     = '0;
   logic [31:0] p_pos      = '0;
   logic        p_dir      = 1'b0;
   logic [31:0] p_last_a   = '0;
   logic [63:0] p_sum      = '0;
   logic [15:0] p_cnt      = '0;
   logic [31:0] p_speed    = '0;
   logic [15:0] p_a_edges  = '0;
   logic [15:0] p_b_edges  = '0;
   logic [15:0] p_win_tmr  = '0;
   logic [15:0] p_bad_win  = '0;
   logic [15:0] p_idle_tmr = '0;

   // encoder pattern generator
   bit          gen_a, gen_b;
   bit          gen_fwd = 1'b1;
   logic [31:0] gen_time;

   enc_status_type status_q[$];
   int             mismatches = 0;
   int unsigned    stall_cycles = 0;
   bit             gaps_off = 1'b0;

   quadrature_encoder_speed_monitor_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_level_a        (req_level_a),
      .req_level_b        (req_level_b),
      .req_timestamp      (req_timestamp),
      .req_speed_commanded(req_speed_commanded),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position       (rsp_position),
      .rsp_direction      (rsp_direction),
      .rsp_speed          (rsp_speed),
      .rsp_fault          (rsp_fault),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic enc_status_type track_encoder(input enc_event_type ev);
      enc_status_type st;
      logic [31:0] period;
      logic [55:0] prod;
      logic [64:0] acc;
      logic [63:0] num;
      logic [63:0] quo;
      logic [15:0] diff;
      if (ev.command == CMD_EDGE_A || ev.command == CMD_EDGE_B) begin
         if (ev.command == CMD_EDGE_A) p_a_edges = p_a_edges + 16'd1;
         else p_b_edges = p_b_edges + 16'd1;
         p_hist = {p_hist[1:0], ev.level_a, ev.level_b};
         if (UP_STEPS[p_hist]) begin
            p_pos = p_pos + 32'd1;
            p_dir = 1'b1;
         end else if (DOWN_STEPS[p_hist]) begin
            p_pos = p_pos - 32'd1;
            p_dir = 1'b0;
         end
         // channel a changed: weigh the period since the previous a change
         if (p_hist[3] != p_hist[1]) begin
            period   = ev.timestamp - p_last_a;
            prod     = 56'(period) * 56'(p_hist[1] ? c_rise : c_fall);
            acc      = 65'(p_sum) + 65'(prod >> WEIGHT_FRAC_DEF);
            p_sum    = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
            p_cnt    = bump16(p_cnt);
            p_last_a = ev.timestamp;
         end
      end else if (ev.command == CMD_TICK) begin
         if (p_win_tmr > c_win) begin
            diff = (p_a_edges > p_b_edges) ? p_a_edges - p_b_edges : p_b_edges - p_a_edges;
            p_bad_win = (diff > c_mis) ? bump16(p_bad_win) : 16'd0;
            if (p_a_edges == 16'd0 && ev.speed_commanded) p_bad_win = bump16(p_bad_win);
            p_a_edges = '0;
            p_b_edges = '0;
            p_win_tmr = '0;
         end
         p_win_tmr = bump16(p_win_tmr);
         if (p_sum != 64'd0 && p_cnt >= 16'(c_min)) begin
            num        = 64'(c_scale) * 64'(p_cnt);
            quo        = num / p_sum;
            p_speed    = (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
            p_sum      = '0;
            p_cnt      = '0;
            p_idle_tmr = '0;
         end
         if (p_idle_tmr >= c_idle) begin
            p_speed    = '0;
            p_sum      = '0;
            p_cnt      = '0;
            p_idle_tmr = '0;
         end
         p_idle_tmr = bump16(p_idle_tmr);
      end
      st.position  = p_pos;
      st.direction = p_dir;
      st.speed     = p_dir ? p_speed : -p_speed;
      st.fault     = (p_bad_win > 16'(c_flt));
      return st;
   endfunction

   function automatic stim_row_type stim_row(input logic [CMD_BITS-1:0] cmd, input bit la,
                                             input bit lb, input logic [31:0] ts,
                                             input bit sc, input bit typed, input int pos,
                                             input bit dir, input int spd, input bit flt);
      stim_row_type r;
      r.ev    = '{command: cmd, level_a: la, level_b: lb, timestamp: ts, speed_commanded: sc};
      r.typed = typed;
      r.st    = '{position: pos, direction: dir, speed: spd, fault: flt};
      return r;
   endfunction

   // mostly clean gray-code steps with random timing, some ticks, some noise
   function automatic enc_event_type encoder_event(input int tick_pct);
      enc_event_type ev;
      int roll;
      roll               = $urandom_range(0, 99);
      ev.level_a         = 1'($urandom_range(0, 1));
      ev.level_b         = 1'($urandom_range(0, 1));
      ev.speed_commanded = 1'($urandom_range(0, 1));
      ev.timestamp       = $urandom;
      if (roll < tick_pct) begin
         ev.command = CMD_TICK;
      end else if (roll < 94) begin
         if ($urandom_range(0, 99) < 3) gen_fwd = !gen_fwd;
         roll = $urandom_range(0, 99);
         if (roll < 5) gen_time = gen_time + $urandom;
         else if (roll < 15) gen_time = gen_time + $urandom_range(1, 4);
         else gen_time = gen_time + $urandom_range(1, 3000);
         // forward order 00 -> 10 -> 11 -> 01
         if ((gen_a == gen_b) == gen_fwd) begin
            ev.command = CMD_EDGE_A;
            gen_a      = !gen_a;
         end else begin
            ev.command = CMD_EDGE_B;
            gen_b      = !gen_b;
         end
         ev.level_a   = gen_a;
         ev.level_b   = gen_b;
         ev.timestamp = gen_time;
      end else begin
         if ($urandom_range(0, 7) == 0) ev.command = CMD_UNUSED;
         else ev.command = $urandom_range(0, 1) ? CMD_EDGE_B : CMD_EDGE_A;
         if (ev.command != CMD_UNUSED) begin
            gen_a = ev.level_a;
            gen_b = ev.level_b;
         end
      end
      return ev;
   endfunction

   // returns right after the edge at which the transfer took place
   task automatic send_event(input enc_event_type ev, input bit typed,
                             input enc_status_type typed_st);
      enc_status_type st;
      while (!gaps_off && $urandom_range(0, 99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= ev.command;
      req_level_a         <= ev.level_a;
      req_level_b         <= ev.level_b;
      req_timestamp       <= ev.timestamp;
      req_speed_commanded <= ev.speed_commanded;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      st = track_encoder(ev);
      status_q.push_back(typed ? typed_st : st);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_RISE_WEIGHT:    c_rise  = val[23:0];
         CSR_FALL_WEIGHT:    c_fall  = val[23:0];
         CSR_SPEED_SCALE:    c_scale = val;
         CSR_MIN_EDGES:      c_min   = val[7:0];
         CSR_IDLE_TICKS:     c_idle  = val[15:0];
         CSR_WINDOW_TICKS:   c_win   = val[15:0];
         CSR_MISMATCH_LIMIT: c_mis   = val[15:0];
         CSR_FAULT_LIMIT:    c_flt   = val[7:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      enc_status_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $error("unexpected result: position %0d speed %0d", rsp_position, rsp_speed);
               mismatches++;
            end else begin
               want = status_q.pop_front();
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", $signed(want.position),
                         rsp_position);
                  mismatches++;
               end
               if (rsp_direction !== want.direction) begin
                  $error("direction: expected %0d, got %0d", want.direction, rsp_direction);
                  mismatches++;
               end
               if (rsp_speed !== want.speed) begin
                  $error("speed: expected %0d, got %0d", $signed(want.speed), rsp_speed);
                  mismatches++;
               end
               if (rsp_fault !== want.fault) begin
                  $error("fault: expected %0d, got %0d", want.fault, rsp_fault);
                  mismatches++;
               end
            end
         end
         rsp_ready <= gaps_off || ($urandom_range(0, 99) >= GAP_PCT);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type   rows[$];
      phase_cfg_type  pc;
      enc_status_type no_status;
      no_status = '0;

      // reset values; typed rows only where the answer is plain
      rows.push_back(stim_row(CMD_TICK,   0, 0, 32'h0000_0000, 1, 1, 0, 0, 0, 0));
      rows.push_back(stim_row(CMD_UNUSED, 1, 1, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_A, 1, 0, 32'd100,       0, 1, 1, 1, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_B, 1, 1, 32'd200,       0, 1, 2, 1, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_A, 0, 1, 32'd300,       1, 1, 3, 1, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_B, 0, 0, 32'd400,       0, 1, 4, 1, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_A, 1, 0, 32'hFFFF_FFFF, 0, 1, 5, 1, 0, 0));
      rows.push_back(stim_row(CMD_TICK,   0, 0, 32'd0,         0, 0, 0, 0, 0, 0));
      // timestamp wraps, direction reverses, speed goes negative
      rows.push_back(stim_row(CMD_EDGE_A, 0, 0, 32'd5,         0, 0, 0, 0, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_B, 0, 1, 32'd10,        1, 0, 0, 0, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_A, 1, 1, 32'd20,        0, 0, 0, 0, 0, 0));
      // no change, then a change of a seen on a b transfer, then a double change
      rows.push_back(stim_row(CMD_EDGE_A, 1, 1, 32'd30,        0, 0, 0, 0, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_B, 0, 0, 32'd40,        1, 0, 0, 0, 0, 0));
      rows.push_back(stim_row(CMD_EDGE_A, 1, 1, 32'd50,        0, 0, 0, 0, 0, 0));
      // speed update, then enough ticks to hit the idle zeroing
      for (int i = 0; i < 11; i++)
         rows.push_back(stim_row(CMD_TICK, i[0], i[1], 32'h8000_0000 >> i, i[0], 0,
                                 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].st);

      gen_a    = p_hist[1];
      gen_b    = p_hist[0];
      gen_time = p_last_a;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         pc.rise     = 24'($urandom_range(0, 24'hFF_FFFF));
         pc.fall     = 24'($urandom_range(0, 24'hFF_FFFF));
         pc.scale    = $urandom;
         if (pc.scale == 32'd0) pc.scale = 32'd1;
         pc.min_e    = 8'($urandom_range(1, 6));
         pc.idle     = 16'($urandom_range(1, 12));
         pc.win      = 16'($urandom_range(1, 30));
         pc.mis      = 16'($urandom_range(0, 6));
         pc.flt      = 8'($urandom_range(0, 4));
         pc.tick_pct = $urandom_range(8, 30);
         pc.count    = 200;
         pc.quiet    = 1'b0;
         case (ph)
            0: begin
               // short windows, no handshake gaps on either side
               pc.rise = 24'h01_0000; pc.fall = 24'h01_0000; pc.scale = 32'd90000000;
               pc.min_e = 8'd1; pc.idle = 16'd1; pc.win = 16'd1; pc.mis = 16'd0;
               pc.flt = 8'd0; pc.tick_pct = 20; pc.count = 250; pc.quiet = 1'b1;
            end
            1: begin
               pc.rise = 24'hFF_FFFF; pc.fall = 24'h00_0000; pc.scale = 32'hFFFF_FFFF;
               pc.min_e = 8'd255; pc.idle = 16'hFFFF; pc.win = 16'hFFFF;
               pc.mis = 16'hFFFF; pc.flt = 8'd255; pc.tick_pct = 3; pc.count = 300;
            end
            2: begin
               // idle_ticks of zero clears the speed on every tick
               pc.rise = 24'h00_0000; pc.fall = 24'hFF_FFFF; pc.scale = 32'd1;
               pc.min_e = 8'd2; pc.idle = 16'd0; pc.win = 16'd3; pc.mis = 16'd1;
               pc.flt = 8'd1; pc.tick_pct = 40; pc.count = 250;
            end
            default: ;
         endcase

         req_valid <= 1'b0;
         while (status_q.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         put_reg(CSR_RISE_WEIGHT, 32'(pc.rise));
         put_reg(CSR_FALL_WEIGHT, 32'(pc.fall));
         put_reg(CSR_SPEED_SCALE, pc.scale);
         put_reg(CSR_MIN_EDGES, 32'(pc.min_e));
         put_reg(CSR_IDLE_TICKS, 32'(pc.idle));
         put_reg(CSR_WINDOW_TICKS, 32'(pc.win));
         put_reg(CSR_MISMATCH_LIMIT, 32'(pc.mis));
         put_reg(CSR_FAULT_LIMIT, 32'(pc.flt));
         csr_wr_en <= 1'b0;
         gaps_off = pc.quiet;

         repeat (pc.count) send_event(encoder_event(pc.tick_pct), 1'b0, no_status);
      end

      req_valid <= 1'b0;
      gaps_off = 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && status_q.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
